// ===== rtl/divisor_count_running_best_top_macros.svh =====
// Assertion macros shared by the divisor counter RTL.
`ifndef DIVISOR_COUNT_RUNNING_BEST_TOP_MACROS_SVH
`define DIVISOR_COUNT_RUNNING_BEST_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DCRB_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DCRB_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dcrb_pkg.sv =====
// Package with the shared constants and helper function of the divisor counter.
package dcrb_pkg;

   localparam int VALUE_BITS_DEF = 20;
   localparam int COUNT_W        = 8;
   localparam int DIV_STEP_BITS  = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   function automatic logic [COUNT_W-1:0] sat_mul(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [2*COUNT_W-1:0] prod;
      begin
         prod = {{COUNT_W{1'b0}}, a} * {{COUNT_W{1'b0}}, b};
         sat_mul = (prod > {{COUNT_W{1'b0}}, COUNT_MAX}) ? COUNT_MAX : prod[COUNT_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/dcrb_div.sv =====
// Iterative restoring divider that retires several quotient bits per cycle.
module dcrb_div #(
   parameter int VALUE_BITS = dcrb_pkg::VALUE_BITS_DEF,
   parameter int D_W        = (VALUE_BITS + 1) / 2 + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [D_W-1:0]        divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [D_W-1:0]        remainder
);
   import dcrb_pkg::*;

   localparam int DIV_W   = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
   localparam int DIV_CYC = DIV_W / DIV_STEP_BITS;
   localparam int CNT_W   = $clog2(DIV_CYC + 1);

   logic [DIV_W-1:0] q_ff, q_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W-1:0] q_step;
   logic [D_W:0]     r_step;

   always_comb begin
      q_step = q_ff;
      r_step = {1'b0, rem_ff};
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         r_step = {r_step[D_W-1:0], q_step[DIV_W-1]};
         q_step = {q_step[DIV_W-2:0], 1'b0};
         if (r_step >= {1'b0, dvs_ff}) begin
            r_step    = r_step - {1'b0, dvs_ff};
            q_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = DIV_W'(dividend);
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_CYC);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = q_step;
         rem_in = r_step[D_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

// ===== rtl/divisor_count_running_best_top.sv =====
// Top level of the divisor counter: factoring sequencer, best-so-far memory, ports.
// Factors out two, then trial-divides by odd divisors up to the square root, repeating
// each division while it is exact; a zero value skips the factoring.
// One request at a time; the next is taken while the last response is still waiting.
// Synchronous active-high reset empties the running best to zero.
`include "divisor_count_running_best_top_macros.svh"

module divisor_count_running_best_top #(
   parameter int VALUE_BITS = dcrb_pkg::VALUE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // value
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // restart
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // divisor_count, best_value, best_count
   output logic [((2 * dcrb_pkg::COUNT_W + VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import dcrb_pkg::*;

   localparam int RSP_W = ((2 * COUNT_W + VALUE_BITS + 7) / 8) * 8;
   localparam int D_W   = (VALUE_BITS + 1) / 2 + 1;
   localparam int SQ_W  = VALUE_BITS + 2;
   localparam int EXP_W = $clog2(VALUE_BITS + 1);
   localparam int MEM_W = VALUE_BITS + COUNT_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_TWO    = 6'b000010,
      S_CHECK  = 6'b000100,
      S_DIV    = 6'b001000,
      S_UPDATE = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic                  restart_ff, restart_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [D_W-1:0]        d_ff, d_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [COUNT_W-1:0]    best_cnt_ff, best_cnt_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic                  best_valid_ff, best_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [MEM_W-1:0]      best_mem [1];
   logic [MEM_W-1:0]      mem_rd_ff;
   logic                  mem_re;
   logic                  mem_we;
   logic [MEM_W-1:0]      mem_wdata;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quot;
   logic [D_W-1:0]        div_rem;

   logic                  req_fire;
   logic [COUNT_W-1:0]    exp_term;
   logic [COUNT_W-1:0]    cur_cnt;
   logic [VALUE_BITS-1:0] cur_val;
   logic                  take_new;

   dcrb_div #(
      .VALUE_BITS(VALUE_BITS),
      .D_W       (D_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign exp_term   = COUNT_W'(exp_ff) + COUNT_W'(1);
   assign cur_cnt    = (restart_ff || !best_valid_ff) ? '0 : mem_rd_ff[COUNT_W-1:0];
   assign cur_val    = (restart_ff || !best_valid_ff) ? '0 : mem_rd_ff[MEM_W-1:COUNT_W];
   assign take_new   = (value_ff != '0) && (total_ff >= cur_cnt);

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      n_in          = n_ff;
      restart_in    = restart_ff;
      total_in      = total_ff;
      exp_in        = exp_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      best_cnt_in   = best_cnt_ff;
      best_val_in   = best_val_ff;
      best_valid_in = best_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = {best_val_in, best_cnt_in};
      div_start     = 1'b0;
      div_dividend  = n_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               value_in   = req_tdata[VALUE_BITS-1:0];
               n_in       = req_tdata[VALUE_BITS-1:0];
               restart_in = req_tuser;
               exp_in     = '0;
               mem_re     = 1'b1;
               if (req_tdata[VALUE_BITS-1:0] == '0) begin
                  total_in = '0;
                  state_in = S_UPDATE;
               end else begin
                  state_in = S_TWO;
               end
            end
         end
         S_TWO: begin
            if (!n_ff[0]) begin
               n_in   = n_ff >> 1;
               exp_in = exp_ff + EXP_W'(1);
            end else begin
               total_in = exp_term;
               exp_in   = '0;
               d_in     = D_W'(3);
               sq_in    = SQ_W'(9);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sq_ff > SQ_W'(n_ff)) begin
               if (n_ff != VALUE_BITS'(1)) begin
                  total_in = sat_mul(total_ff, COUNT_W'(2));
               end
               state_in = S_UPDATE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  n_in         = div_quot;
                  exp_in       = exp_ff + EXP_W'(1);
                  div_start    = 1'b1;
                  div_dividend = div_quot;
               end else begin
                  if (exp_ff != '0) begin
                     total_in = sat_mul(total_ff, exp_term);
                  end
                  exp_in   = '0;
                  d_in     = d_ff + D_W'(2);
                  sq_in    = sq_ff + (SQ_W'(d_ff) << 2) + SQ_W'(4);
                  state_in = S_CHECK;
               end
            end
         end
         S_UPDATE: begin
            best_cnt_in   = take_new ? total_ff : cur_cnt;
            best_val_in   = take_new ? value_ff : cur_val;
            mem_we        = 1'b1;
            mem_wdata     = {best_val_in, best_cnt_in};
            best_valid_in = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({best_cnt_ff, best_val_ff, total_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         best_mem[0] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= best_mem[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      n_ff        <= n_in;
      restart_ff  <= restart_in;
      total_ff    <= total_in;
      exp_ff      <= exp_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      best_cnt_ff <= best_cnt_in;
      best_val_ff <= best_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `DCRB_CHECK(a_odd_trial, state_ff == S_CHECK, d_ff[0] == 1'b1, "Trial divisor is even.")
   `DCRB_CHECK(a_square_track, state_ff == S_CHECK, sq_ff == SQ_W'(d_ff) * SQ_W'(d_ff), "Square of the trial divisor is out of step.")
   `DCRB_CHECK_NEXT(a_best_written, state_ff == S_UPDATE, best_valid_ff && state_ff == S_OUT, "Best entry was not written back.")
   `DCRB_CHECK(a_best_covers, rsp_valid_ff, rsp_data_ff[2*COUNT_W+VALUE_BITS-1:COUNT_W+VALUE_BITS] >= rsp_data_ff[COUNT_W-1:0], "Best count is below the current count.")

endmodule

// ===== test/divisor_count_running_best_checker.sv =====
// Checker that predicts each divisor count and running best and compares every response.
module divisor_count_running_best_checker #(
   parameter int VALUE_BITS = dcrb_pkg::VALUE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [((2 * dcrb_pkg::COUNT_W + VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output int   mismatch_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = dcrb_pkg::COUNT_W;
   localparam logic [CW-1:0] COUNT_CAP = dcrb_pkg::COUNT_MAX;

   typedef struct packed {
      logic [CW-1:0]         divisor_count;
      logic [VALUE_BITS-1:0] best_value;
      logic [CW-1:0]         best_count;
   } divisor_tally_type;

   divisor_tally_type     awaited_tallies[$];
   logic [CW-1:0]         best_count_now;
   logic [VALUE_BITS-1:0] best_value_now;

   function automatic logic [CW-1:0] capped_product(input int unsigned a,
                                                    input int unsigned b);
      int unsigned p;
      p = a * b;
      return (p > COUNT_CAP) ? COUNT_CAP : p[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] count_divisors(input logic [VALUE_BITS-1:0] value);
      int unsigned n;
      int unsigned d;
      int unsigned exponent;
      int unsigned total;
      if (value == '0) begin
         return '0;
      end
      n = 32'(value);
      exponent = 0;
      while ((n & 1) == 0) begin
         n = n >> 1;
         exponent++;
      end
      total = 32'(capped_product(1, exponent + 1));
      for (d = 3; d * d <= n; d += 2) begin
         if (n % d == 0) begin
            exponent = 0;
            while (n % d == 0) begin
               n = n / d;
               exponent++;
            end
            total = 32'(capped_product(total, exponent + 1));
         end
      end
      if (n != 1) begin
         total = 32'(capped_product(total, 2));
      end
      return total[CW-1:0];
   endfunction

   always @(posedge clock) begin
      divisor_tally_type     seen;
      divisor_tally_type     want;
      logic [VALUE_BITS-1:0] value;
      logic [CW-1:0]         tau;
      if (reset) begin
         awaited_tallies.delete();
         best_count_now = '0;
         best_value_now = '0;
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.divisor_count = rsp_tdata[CW-1:0];
            seen.best_value    = rsp_tdata[CW +: VALUE_BITS];
            seen.best_count    = rsp_tdata[CW + VALUE_BITS +: CW];
            if (awaited_tallies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected response: divisor_count %0d best_value %0d best_count %0d",
                           seen.divisor_count, seen.best_value, seen.best_count);
               end
            end else begin
               want = awaited_tallies.pop_front();
               if (seen.divisor_count !== want.divisor_count ||
                   seen.best_value !== want.best_value ||
                   seen.best_count !== want.best_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch (expected/actual): divisor_count %0d/%0d %s %0d/%0d %s %0d/%0d",
                              want.divisor_count, seen.divisor_count,
                              "best_value", want.best_value, seen.best_value,
                              "best_count", want.best_count, seen.best_count);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            value = req_tdata[VALUE_BITS-1:0];
            if (req_tuser) begin
               best_count_now = '0;
               best_value_now = '0;
            end
            tau = count_divisors(value);
            if (value != '0 && tau >= best_count_now) begin
               best_count_now = tau;
               best_value_now = value;
            end
            want.divisor_count = tau;
            want.best_value    = best_value_now;
            want.best_count    = best_count_now;
            awaited_tallies = {awaited_tallies, want};
         end
         outstanding = awaited_tallies.size();
      end
   end

endmodule

// ===== test/divisor_count_running_best_top_tb.sv =====
// Testbench top for the divisor counter: clock, reset, request stimulus, verdict.
module divisor_count_running_best_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS       = dcrb_pkg::VALUE_BITS_DEF;
   localparam int REQ_W            = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_W            = ((2 * dcrb_pkg::COUNT_W + VALUE_BITS + 7) / 8) * 8;
   localparam int RANDOM_REQUESTS  = 120;
   localparam int STALL_LIMIT      = 40000;
   localparam int LONG_HOLD_CYCLES = 8000;
   localparam int DRAIN_CYCLES     = 4000;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int idle_cycles = 0;
   bit quiet_phase = 1'b0;
   bit hold_request = 1'b0;

   divisor_count_running_best_top #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   divisor_count_running_best_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("divisor_count_running_best_top test failed");
         $finish;
      end
   end

   function automatic int sender_gap();
      int r;
      if (quiet_phase) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 20);
      end else begin
         return $urandom_range(40, 150);
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int unsigned r;
      int unsigned v;
      int unsigned p;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         v = $urandom_range(1, 4095);
      end else if (r < 55) begin
         v = $urandom_range(4096, 65535);
      end else if (r < 70) begin
         v = $urandom_range(0, VALUE_MAX);
      end else if (r < 88) begin
         v = 1;
         repeat ($urandom_range(2, 14)) begin
            case ($urandom_range(0, 5))
               0: p = 2;
               1: p = 3;
               2: p = 5;
               3: p = 7;
               4: p = 11;
               default: p = 13;
            endcase
            if (v * p <= VALUE_MAX) begin
               v = v * p;
            end
         end
      end else if (r < 97) begin
         v = $urandom_range(VALUE_MAX / 2 + 1, VALUE_MAX);
      end else begin
         v = 0;
      end
      return v[VALUE_BITS-1:0];
   endfunction

   task automatic send_request(input logic [VALUE_BITS-1:0] value, input bit restart,
                               input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(value);
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (quiet_phase || $urandom_range(0, 99) < 75) begin
            rsp_tready <= 1'b1;
         end else begin
            if ($urandom_range(0, 99) < 85) begin
               stall_left = $urandom_range(0, 2);
            end else if ($urandom_range(0, 99) < 80) begin
               stall_left = $urandom_range(3, 15);
            end else begin
               stall_left = $urandom_range(30, 120);
            end
            rsp_tready <= 1'b0;
         end
      end
   end

   initial begin
      int gap;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(20'd0, 1'b0, sender_gap());
      send_request(20'd1, 1'b0, sender_gap());
      send_request(20'd2, 1'b0, sender_gap());
      send_request(20'd3, 1'b0, sender_gap());
      send_request(20'd4, 1'b0, sender_gap());
      send_request(20'd9, 1'b0, sender_gap());
      send_request(VALUE_MAX, 1'b0, sender_gap());
      send_request(20'd524288, 1'b0, sender_gap());
      send_request(20'd999983, 1'b0, sender_gap());
      send_request(20'd1000000, 1'b0, sender_gap());
      send_request(20'd1000005, 1'b0, sender_gap());
      send_request(20'd720720, 1'b0, sender_gap());
      send_request(20'd831600, 1'b0, sender_gap());
      send_request(20'd1018081, 1'b0, sender_gap());
      send_request(20'd1046529, 1'b0, sender_gap());
      send_request(20'd1048573, 1'b0, sender_gap());
      send_request(20'd0, 1'b1, sender_gap());
      send_request(20'd1, 1'b0, sender_gap());
      send_request(20'd65536, 1'b1, sender_gap());
      send_request(20'd997, 1'b0, sender_gap());
      send_request(VALUE_MAX, 1'b1, sender_gap());
      drain_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         quiet_phase = ((i / 25) % 3) == 1;
         if (i == 10) begin
            hold_request = 1'b1;
         end
         if (i == 70) begin
            drain_results();
         end
         gap = (i >= 10 && i < 18) ? 0 : sender_gap();
         send_request(pick_value(), $urandom_range(0, 9) == 0, gap);
      end
      quiet_phase = 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("divisor_count_running_best_top test passed");
      end else begin
         $display("divisor_count_running_best_top test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dcrb_pkg.sv
rtl/dcrb_div.sv
rtl/divisor_count_running_best_top.sv
test/divisor_count_running_best_checker.sv
test/divisor_count_running_best_top_tb.sv
